@@ design/small_cpu_execute_unit_core_assert.svh @@
// Assertion macros for the small CPU execute unit
`ifndef SMALL_CPU_EXECUTE_UNIT_CORE_ASSERT_SVH
`define SMALL_CPU_EXECUTE_UNIT_CORE_ASSERT_SVH
// Implication checked every clock outside reset
`define SCEU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset
`define SCEU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ design/sceu_pkg.sv @@
// ----------------------------------------------------------------------------
// sceu_pkg
// Types and constants shared by the small CPU execute unit modules.
// ----------------------------------------------------------------------------
package sceu_pkg;

   localparam logic [4:0] OP_AND  = 5'd0;
   localparam logic [4:0] OP_OR   = 5'd1;
   localparam logic [4:0] OP_XOR  = 5'd2;
   localparam logic [4:0] OP_MUL  = 5'd3;
   localparam logic [4:0] OP_DIV  = 5'd4;
   localparam logic [4:0] OP_ADD  = 5'd5;
   localparam logic [4:0] OP_SUB  = 5'd6;
   localparam logic [4:0] OP_SHF  = 5'd7;
   localparam logic [4:0] OP_LDB  = 5'd8;
   localparam logic [4:0] OP_LDH  = 5'd9;
   localparam logic [4:0] OP_LDW  = 5'd10;
   localparam logic [4:0] OP_STB  = 5'd11;
   localparam logic [4:0] OP_STH  = 5'd12;
   localparam logic [4:0] OP_STW  = 5'd13;
   localparam logic [4:0] OP_JMP  = 5'd14;
   localparam logic [4:0] OP_JZS  = 5'd15;
   localparam logic [4:0] OP_JZC  = 5'd16;
   localparam logic [4:0] OP_JCS  = 5'd17;
   localparam logic [4:0] OP_JCC  = 5'd18;
   localparam logic [4:0] OP_JNS  = 5'd19;
   localparam logic [4:0] OP_JNC  = 5'd20;
   localparam logic [4:0] OP_OUT  = 5'd22;
   localparam logic [4:0] OP_HALT = 5'd31;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_HALTED = 2'd1;
   localparam logic [1:0] ST_UNSUP  = 2'd2;
   localparam logic [1:0] ST_DIVZ   = 2'd3;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        flag_z;
      logic        flag_n;
      logic        flag_c;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic [1:0]  status;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_instr;  // capture request word
      logic load_ops;    // capture operands from register file
      logic div_start;   // start the divider
      logic div_step;    // one divider iteration
      logic mem_start;   // start a byte access sequence
      logic mem_step;    // advance byte access
      logic commit;      // finish the instruction, build response
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic       is_div;
      logic       is_mem;
      logic       div_zero;
      logic       div_done;
      logic       mem_done;
      logic       halted;
   } sts_type;

endpackage

@@ design/sceu_if.sv @@
// ----------------------------------------------------------------------------
// sceu_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface sceu_if #(parameter int W = 32);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/sceu_ram.sv @@
// ----------------------------------------------------------------------------
// sceu_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module sceu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

@@ design/sceu_ctrl.sv @@
// ----------------------------------------------------------------------------
// sceu_ctrl
// Controller state machine sequencing fetch, execute, memory and divide.
// ----------------------------------------------------------------------------
module sceu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sceu_pkg::sts_type sts,
   output sceu_pkg::cmd_type cmd
);
   import sceu_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_OPS  = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_MEM  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Output register: a new request is taken while it is empty or being read
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_instr = 1'b1;
               state_in = S_OPS;
            end
         end
         S_OPS: begin
            cmd.load_ops = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!sts.halted && sts.is_div && !sts.div_zero) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else if (!sts.halted && sts.is_mem) begin
               cmd.mem_start = 1'b1;
               state_in = S_MEM;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_MEM: begin
            cmd.mem_step = 1'b1;
            if (sts.mem_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `include "small_cpu_execute_unit_core_assert.svh"
   `SCEU_ASSERT_IMPL(a_commit_room, clock, reset, cmd.commit, !rsp_valid_ff || rsp_ready)
   `SCEU_ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_valid_ff)
   `SCEU_ASSERT_NEXT(a_accept_ops, clock, reset, cmd.load_instr, state_ff == S_OPS)
endmodule

@@ design/sceu_dp.sv @@
// ----------------------------------------------------------------------------
// sceu_dp
// Datapath: register file, flags, PC, ALU, serial divider, byte memory port.
// ----------------------------------------------------------------------------
module sceu_dp #(
   parameter int MEM_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       instr,
   input  sceu_pkg::cmd_type cmd,
   output sceu_pkg::sts_type sts,
   output sceu_pkg::rsp_type rsp
);
   import sceu_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);

   logic [31:0] ir_ff;
   logic [31:0] rf_ff [32];
   logic [31:0] pc_ff;
   logic        z_ff, n_ff, c_ff, halt_ff;
   logic [31:0] a_ff, x_ff, d_ff;
   rsp_type     rsp_ff;

   logic [4:0]  op, rd, rn;
   logic        imm;
   logic [31:0] simm;
   assign op   = ir_ff[31:27];
   assign rd   = ir_ff[26:22];
   assign rn   = ir_ff[21:17];
   assign imm  = ir_ff[16];
   assign simm = {{16{ir_ff[15]}}, ir_ff[15:0]};

   // Instruction and operand capture
   always_ff @(posedge clock) begin
      if (cmd.load_instr) begin
         ir_ff <= instr;
      end
      if (cmd.load_ops) begin
         a_ff <= rf_ff[rn];
         x_ff <= imm ? simm : rf_ff[ir_ff[4:0]];
         d_ff <= rf_ff[rd];
      end
   end

   // Serial restoring divider on magnitudes, one quotient bit a cycle
   logic [31:0] dq_ff, dr_ff, dv_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_ff;
   logic [32:0] dtrial;
   logic [31:0] dr_sh;
   assign dr_sh  = {dr_ff[30:0], dq_ff[31]};
   assign dtrial = {1'b0, dr_sh} - {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff   <= a_ff[31] ? (32'd0 - a_ff) : a_ff;
         dv_ff   <= x_ff[31] ? (32'd0 - x_ff) : x_ff;
         dr_ff   <= '0;
         dcnt_ff <= '0;
         dneg_ff <= a_ff[31] ^ x_ff[31];
      end else if (cmd.div_step && dcnt_ff != 6'd32) begin
         dcnt_ff <= dcnt_ff + 6'd1;
         if (!dtrial[32]) begin
            dr_ff <= dtrial[31:0];
            dq_ff <= {dq_ff[30:0], 1'b1};
         end else begin
            dr_ff <= dr_sh;
            dq_ff <= {dq_ff[30:0], 1'b0};
         end
      end
   end

   // Byte memory sequencer, big-endian
   logic [2:0]    mcnt_ff;
   logic [31:0]   maddr_ff, mdata_ff;
   logic [2:0]    mlen;
   logic          mstore;
   logic [AW-1:0] ram_addr;
   logic          ram_we;
   logic [7:0]    ram_wd, ram_rd;
   logic [31:0]   byte_addr;
   logic [1:0]    bsel;

   assign mstore = (op == OP_STB) || (op == OP_STH) || (op == OP_STW);
   always_comb begin
      case (op)
         OP_LDB, OP_STB: mlen = 3'd1;
         OP_LDH, OP_STH: mlen = 3'd2;
         default:        mlen = 3'd4;
      endcase
   end
   assign byte_addr = maddr_ff + {29'd0, mcnt_ff};
   assign ram_addr  = byte_addr[AW-1:0];
   assign ram_we    = cmd.mem_step && mstore && (mcnt_ff < mlen);
   assign bsel      = 2'(mlen - 3'd1 - mcnt_ff);
   assign ram_wd    = a_ff[8*bsel +: 8];

   sceu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   // Read data comes from the registered RAM read; shift in from count 1 on
   always_ff @(posedge clock) begin
      if (cmd.mem_start) begin
         mcnt_ff  <= '0;
         mdata_ff <= '0;
         maddr_ff <= (mstore ? d_ff : a_ff) + x_ff;
      end else if (cmd.mem_step) begin
         mcnt_ff <= mcnt_ff + 3'd1;
         if (mcnt_ff != 3'd0) begin
            mdata_ff <= {mdata_ff[23:0], ram_rd};
         end
      end
   end

   assign sts.is_div   = (op == OP_DIV);
   assign sts.is_mem   = (op inside {[OP_LDB:OP_STW]});
   assign sts.div_zero = (x_ff == 32'd0);
   assign sts.div_done = (dcnt_ff == 6'd32);
   assign sts.mem_done = (mcnt_ff == mlen);
   assign sts.halted   = halt_ff;

   // Execute results
   logic [31:0] mn, ms, prod, shres, res, nxt, quo, ldv;
   logic [32:0] sum, dif;
   logic        shc, writes, take, nz, nn, nc;
   logic [1:0]  status;
   logic        wr;
   logic [4:0]  idx;
   logic [31:0] val;
   logic [5:0]  sk;
   logic [63:0] sext, lsh;

   // 16-bit magnitudes held in 32-bit words, upper halves zero
   assign mn   = {16'd0, a_ff[15:0]};
   assign ms   = imm ? (simm[31] ? (32'd0 - simm) : simm) : {16'd0, x_ff[15:0]};
   assign prod = mn * ms;
   assign sum  = {1'b0, a_ff} + {1'b0, x_ff};
   assign dif  = {1'b0, a_ff} - {1'b0, x_ff};
   assign quo  = dneg_ff ? (32'd0 - dq_ff) : dq_ff;
   assign sext = {{32{a_ff[31]}}, a_ff};
   assign lsh  = {32'd0, a_ff} << sk;

   // Shift: magnitude clamps keep the shifter at 6 bits of amount
   always_comb begin
      sk    = '0;
      shres = a_ff;
      shc   = 1'b0;
      if (x_ff == 32'd0) begin
         shres = a_ff;
         shc   = 1'b0;
      end else if (!x_ff[31]) begin
         if (x_ff < 32'd32) begin
            sk    = x_ff[5:0];
            shres = 32'(sext >> sk);
            shc   = a_ff[5'(sk - 6'd1)];
         end else begin
            shres = {32{a_ff[31]}};
            shc   = a_ff[31];
         end
      end else begin
         if ((32'd0 - x_ff) <= 32'd32) begin
            sk    = 6'(32'd0 - x_ff);
            shres = lsh[31:0];
            shc   = lsh[32];
         end else begin
            shres = '0;
            shc   = 1'b0;
         end
      end
   end

   always_comb begin
      case (mlen)
         3'd1:    ldv = {{24{mdata_ff[7]}}, mdata_ff[7:0]};
         3'd2:    ldv = {{16{mdata_ff[15]}}, mdata_ff[15:0]};
         default: ldv = mdata_ff;
      endcase
   end

   always_comb begin
      case (op)
         OP_JZS:  take = z_ff;
         OP_JZC:  take = !z_ff;
         OP_JCS:  take = c_ff;
         OP_JCC:  take = !c_ff;
         OP_JNS:  take = n_ff;
         OP_JNC:  take = !n_ff;
         default: take = 1'b1;
      endcase
   end

   always_comb begin
      res    = '0;
      writes = 1'b0;
      nz     = z_ff;
      nn     = n_ff;
      nc     = c_ff;
      status = ST_OK;
      wr     = 1'b0;
      idx    = '0;
      val    = '0;
      nxt    = pc_ff + 32'd4;
      if (halt_ff) begin
         status = ST_HALTED;
         nxt    = pc_ff;
      end else begin
         case (op)
            OP_AND: begin res = a_ff & x_ff; nc = 1'b0; writes = 1'b1; end
            OP_OR:  begin res = a_ff | x_ff; nc = 1'b0; writes = 1'b1; end
            OP_XOR: begin res = a_ff ^ x_ff; nc = 1'b0; writes = 1'b1; end
            OP_MUL: begin
               res    = (a_ff[31] ^ x_ff[31]) ? (32'd0 - prod) : prod;
               writes = 1'b1;
            end
            OP_DIV: begin
               if (x_ff == 32'd0) begin
                  status = ST_DIVZ;
                  nxt    = pc_ff;
               end else begin
                  res = quo; nc = 1'b0; writes = 1'b1;
               end
            end
            OP_ADD: begin res = sum[31:0]; nc = sum[32]; writes = 1'b1; end
            OP_SUB: begin res = dif[31:0]; nc = dif[32]; writes = 1'b1; end
            OP_SHF: begin res = shres; nc = shc; writes = 1'b1; end
            OP_LDB, OP_LDH, OP_LDW: begin
               wr = 1'b1; idx = rd; val = ldv;
            end
            OP_STB, OP_STH, OP_STW: begin end
            OP_JMP, OP_JZS, OP_JZC, OP_JCS, OP_JCC, OP_JNS, OP_JNC: begin
               if (take) nxt = x_ff;
               nc = 1'b0;
            end
            OP_OUT: begin
               nz = (d_ff == 32'd0); nn = d_ff[31]; idx = rd; val = d_ff;
            end
            OP_HALT: begin nxt = 32'hFFFF_FFFF; status = ST_HALTED; end
            default: begin status = ST_UNSUP; nxt = pc_ff; end
         endcase
         if (writes) begin
            nz = (res == 32'd0); nn = res[31]; wr = 1'b1; idx = rd; val = res;
         end
      end
   end

   // Architectural state update on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) rf_ff[i] <= '0;
         pc_ff   <= '0;
         z_ff    <= 1'b0;
         n_ff    <= 1'b0;
         c_ff    <= 1'b0;
         halt_ff <= 1'b0;
      end else if (cmd.commit) begin
         if (wr) rf_ff[idx] <= val;
         z_ff <= nz;
         n_ff <= nn;
         c_ff <= nc;
         if (!halt_ff && status != ST_UNSUP && status != ST_DIVZ) pc_ff <= nxt;
         if (!halt_ff && op == OP_HALT) halt_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= '{next_pc: nxt, flag_z: nz, flag_n: nn, flag_c: nc,
                     reg_written: wr, dest_index: idx, dest_value: val,
                     status: status};
      end
   end
   assign rsp = rsp_ff;

   `include "small_cpu_execute_unit_core_assert.svh"
   `SCEU_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff)
   `SCEU_ASSERT_IMPL(a_div_bounded, clock, reset, cmd.div_step, dcnt_ff <= 6'd32)
endmodule

@@ design/small_cpu_execute_unit_core.sv @@
// ----------------------------------------------------------------------------
// small_cpu_execute_unit_core
// Execute unit of a small 32-bit processor, one instruction per request.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one 32-bit instruction word per request. rsp channel
//   returns one result per request: next PC, Z/N/C flags, register write
//   report and status.
// Sequencing:
//   Every instruction passes through the OPS, EXEC and DONE states after
//   accept. Loads and stores add a MEM state that walks the byte memory
//   port one byte a cycle. A nonzero divide adds a DIV state with a
//   one-bit-per-cycle serial divider. One instruction is in flight at a
//   time; a request is taken when the output register is empty or read.
// Reset:
//   Synchronous reset clears registers, PC, flags and the halted state.
//   Data memory holds no reset value; read only bytes already written.
// Stall:
//   While rsp_ready is low the response holds in its output register and
//   a finished instruction waits before committing.
// ----------------------------------------------------------------------------
module small_cpu_execute_unit_core #(
   parameter int MEM_BYTES = 4096
) (
   input  logic  clock,
   input  logic  reset,
   sceu_if.sink   req,
   sceu_if.source rsp
);
   import sceu_pkg::*;

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_data;

   sceu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sceu_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
      .clock (clock),
      .reset (reset),
      .instr (req.data[31:0]),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_data)
   );

   assign rsp.data = rsp_data;
endmodule
